### src/ptach_pkg.sv
package ptach_pkg;

  localparam int PIN_W   = 16;
  localparam int SPEED_W = 19;
  localparam int WCNT_W  = 16;
  localparam int REG_W   = 16;
  localparam int ADDR_W  = 4;
  localparam int TDATA_OUT_W = 40;

  typedef enum logic [1:0] {
    REG_TACH_PIN_MASK = 2'd0,
    REG_SLEW_STEP     = 2'd1,
    REG_MIN_RPM       = 2'd2,
    REG_MAX_RPM       = 2'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_EDGE = 1'b1
  } kind_t;

  localparam logic [REG_W-1:0] RST_TACH_PIN_MASK = 16'd128;
  localparam logic [REG_W-1:0] RST_SLEW_STEP     = 16'd100;
  localparam logic [REG_W-1:0] RST_MIN_RPM       = 16'd500;
  localparam logic [REG_W-1:0] RST_MAX_RPM       = 16'd3000;

endpackage

### src/pulse_tachometer_rpm_filter_top.sv
// Channel  | Direction | Word                                             | Handshake
// ---------+-----------+--------------------------------------------------+----------------
// s_axis   | in        | tdata[15:0] pin_mask, tuser[0] kind              | tvalid/tready
// m_axis   | out       | tdata[18:0] speed_eighths, [34:19] window_count  | tvalid/tready
// apb      | in        | four 16-bit registers at byte addresses 0,4,8,12 | psel/penable
//
// One word per cycle sustained while no tick waits on a stalled result register.
// The input register feeds one pass of count, average, slew and clamp into the
// result register. Edge words update the counter only and give no result.
// A tick waiting on a stalled result register holds the input register.
// rst is synchronous, active high, and restores counter, averages and registers.
module pulse_tachometer_rpm_filter_top #(
  parameter int COUNT_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ptach_pkg::PIN_W-1:0]           s_axis_tdata,  // pin_mask
  input  logic                                  s_axis_tuser,  // kind
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [ptach_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,  // speed_eighths, window_count
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ptach_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int RAW_W    = COUNT_BITS + 6;
  localparam int SMOOTH_W = RAW_W + FRAC_BITS;
  localparam int SLEW_W   = COUNT_BITS + 7;
  localparam int CMP_W    = ((SLEW_W > 17) ? SLEW_W : 17) + FRAC_BITS;
  localparam int WIDE_W   = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int SPD_W    = (SLEW_W > 16) ? SLEW_W : 16;
  localparam int RW       = ptach_pkg::REG_W;

  logic [RW-1:0] tach_pin_mask;
  logic [RW-1:0] slew_step;
  logic [RW-1:0] min_rpm;
  logic [RW-1:0] max_rpm;

  logic                        s1_valid;
  ptach_pkg::kind_t            s1_kind;
  logic [ptach_pkg::PIN_W-1:0] s1_pin;
  logic                        s1_go;

  logic [COUNT_BITS-1:0] edge_count;
  logic [COUNT_BITS-1:0] edge_count_next;
  logic [SMOOTH_W-1:0]   smoothed_rpm;
  logic [SMOOTH_W-1:0]   smoothed_rpm_next;
  logic [SLEW_W-1:0]     slewed_rpm;
  logic [SLEW_W-1:0]     slewed_rpm_next;

  logic [RAW_W-1:0]      raw_rpm;
  logic [SMOOTH_W-1:0]   raw_fx;
  logic [SMOOTH_W:0]     smooth_sum;
  logic [CMP_W-1:0]      s_fx;
  logic [CMP_W-1:0]      sm_fx;
  logic [CMP_W-1:0]      t_fx;
  logic [SPD_W-1:0]      slew_ext;
  logic [RW-1:0]         clamped;
  logic [ptach_pkg::SPEED_W-1:0] speed;
  logic [WIDE_W-1:0]     count_ext;
  logic                  cfg_wr;
  logic                  tick_go;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tach_pin_mask <= ptach_pkg::RST_TACH_PIN_MASK;
      slew_step     <= ptach_pkg::RST_SLEW_STEP;
      min_rpm       <= ptach_pkg::RST_MIN_RPM;
      max_rpm       <= ptach_pkg::RST_MAX_RPM;
    end else if (cfg_wr) begin
      case (ptach_pkg::reg_idx_t'(paddr[3:2]))
        ptach_pkg::REG_TACH_PIN_MASK: tach_pin_mask <= pwdata[RW-1:0];
        ptach_pkg::REG_SLEW_STEP:     slew_step     <= pwdata[RW-1:0];
        ptach_pkg::REG_MIN_RPM:       min_rpm       <= pwdata[RW-1:0];
        ptach_pkg::REG_MAX_RPM:       max_rpm       <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ptach_pkg::reg_idx_t'(paddr[3:2]))
      ptach_pkg::REG_TACH_PIN_MASK: prdata = 32'(tach_pin_mask);
      ptach_pkg::REG_SLEW_STEP:     prdata = 32'(slew_step);
      ptach_pkg::REG_MIN_RPM:       prdata = 32'(min_rpm);
      ptach_pkg::REG_MAX_RPM:       prdata = 32'(max_rpm);
      default:                      prdata = '0;
    endcase
  end

  assign s1_go = s1_valid &&
                 (s1_kind == ptach_pkg::KIND_EDGE || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_go;
  assign tick_go = s1_go && (s1_kind == ptach_pkg::KIND_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_kind <= ptach_pkg::kind_t'(s_axis_tuser);
      s1_pin  <= s_axis_tdata;
    end
  end

  always_comb begin
    edge_count_next   = edge_count;
    smoothed_rpm_next = smoothed_rpm;
    slewed_rpm_next   = slewed_rpm;

    raw_rpm    = {edge_count, 6'b0} - {4'b0, edge_count, 2'b0};
    raw_fx     = SMOOTH_W'(raw_rpm) << FRAC_BITS;
    smooth_sum = {1'b0, smoothed_rpm} + {1'b0, raw_fx};
    sm_fx      = CMP_W'(smooth_sum[SMOOTH_W:1]);
    s_fx       = CMP_W'(slewed_rpm) << FRAC_BITS;
    t_fx       = CMP_W'(slew_step) << FRAC_BITS;

    if (s1_go) begin
      if (s1_kind == ptach_pkg::KIND_EDGE) begin
        if (s1_pin == tach_pin_mask && edge_count != '1) begin
          edge_count_next = edge_count + COUNT_BITS'(1);
        end
      end else begin
        edge_count_next   = '0;
        smoothed_rpm_next = smooth_sum[SMOOTH_W:1];
        if (s_fx >= sm_fx) begin
          if ((s_fx - sm_fx) >= t_fx) begin
            slewed_rpm_next = slewed_rpm - SLEW_W'(slew_step);
          end
        end else begin
          if ((sm_fx - s_fx) >= t_fx) begin
            slewed_rpm_next = slewed_rpm + SLEW_W'(slew_step);
          end
        end
      end
    end

    slew_ext  = SPD_W'(slewed_rpm_next);
    clamped   = (slew_ext > SPD_W'(max_rpm)) ? max_rpm : slew_ext[RW-1:0];
    speed     = (slew_ext >= SPD_W'(min_rpm)) ? {clamped, 3'b0} : '0;
    count_ext = WIDE_W'(edge_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      smoothed_rpm  <= '0;
      slewed_rpm    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      edge_count   <= edge_count_next;
      smoothed_rpm <= smoothed_rpm_next;
      slewed_rpm   <= slewed_rpm_next;
      if (tick_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      m_axis_tdata <= {5'b0, count_ext[ptach_pkg::WCNT_W-1:0], speed};
    end
  end

  a_tick_clears_count: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> edge_count == '0)
    else $error("edge counter not cleared by window tick");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(tick_go))
    else $error("result word without a window tick");

  a_window_count: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> m_axis_tdata[34:19] == $past(count_ext[ptach_pkg::WCNT_W-1:0]))
    else $error("window count does not match latched counter");

endmodule

### sim/pulse_tachometer_rpm_filter_top_tb.sv
module pulse_tachometer_rpm_filter_top_tb;

  localparam int FRAC_BITS = 8;
  localparam int RPM_PER_EDGE = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [ptach_pkg::SPEED_W-1:0] speed_eighths;
    logic [ptach_pkg::WCNT_W-1:0]  window_count;
  } speed_word_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [ptach_pkg::PIN_W-1:0]       s_axis_tdata = '0;  // pin_mask
  logic                              s_axis_tuser = 1'b0;  // kind
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [ptach_pkg::TDATA_OUT_W-1:0] m_axis_tdata;  // speed_eighths, window_count
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [ptach_pkg::ADDR_W-1:0]      paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;

  logic [ptach_pkg::REG_W-1:0] cfg_pin_mask = ptach_pkg::RST_TACH_PIN_MASK;
  logic [ptach_pkg::REG_W-1:0] cfg_slew_step = ptach_pkg::RST_SLEW_STEP;
  logic [ptach_pkg::REG_W-1:0] cfg_min_rpm = ptach_pkg::RST_MIN_RPM;
  logic [ptach_pkg::REG_W-1:0] cfg_max_rpm = ptach_pkg::RST_MAX_RPM;
  logic [15:0]      edge_cnt = '0;
  logic [29:0]      smooth_fx = '0;
  logic [22:0]      slew_rpm = '0;

  speed_word_t pending_speeds[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches = 0;
  int n_checked = 0;
  int n_edges = 0;
  int n_writes = 0;
  int cycles = 0;

  pulse_tachometer_rpm_filter_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void note_fail(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void count_edge(input logic [ptach_pkg::PIN_W-1:0] pin);
    if (pin == cfg_pin_mask && edge_cnt != COUNT_MAX) edge_cnt++;
  endfunction

  function automatic speed_word_t close_window();
    logic [31:0] raw_fx, sum_fx, s_fx, t_fx;
    logic [15:0] ceil_rpm;
    speed_word_t w;
    raw_fx = (32'(edge_cnt) * RPM_PER_EDGE) << FRAC_BITS;
    sum_fx = 32'(smooth_fx) + raw_fx;
    smooth_fx = sum_fx[30:1];
    s_fx = 32'(slew_rpm) << FRAC_BITS;
    t_fx = 32'(cfg_slew_step) << FRAC_BITS;
    if (s_fx >= 32'(smooth_fx)) begin
      if (s_fx - 32'(smooth_fx) >= t_fx) slew_rpm = slew_rpm - cfg_slew_step;
    end else if (32'(smooth_fx) - s_fx >= t_fx) begin
      slew_rpm = slew_rpm + cfg_slew_step;
    end
    w.window_count = edge_cnt;
    edge_cnt = '0;
    if (slew_rpm >= 23'(cfg_min_rpm)) begin
      ceil_rpm = (slew_rpm > 23'(cfg_max_rpm)) ? cfg_max_rpm : slew_rpm[15:0];
      w.speed_eighths = {ceil_rpm, 3'b000};
    end else begin
      w.speed_eighths = '0;
    end
    return w;
  endfunction

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    speed_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_speeds.size() == 0) begin
        note_fail($sformatf("Unexpected speed word: speed_eighths %0d window_count %0d",
                            m_axis_tdata[18:0], m_axis_tdata[34:19]));
      end else begin
        want = pending_speeds.pop_front();
        if (m_axis_tdata[18:0] !== want.speed_eighths ||
            m_axis_tdata[34:19] !== want.window_count) begin
          note_fail($sformatf({"Speed word %0d: speed_eighths exp %0d got %0d, ",
                               "window_count exp %0d got %0d"}, n_checked,
                              want.speed_eighths, m_axis_tdata[18:0],
                              want.window_count, m_axis_tdata[34:19]));
        end
        n_checked++;
      end
    end
  end

  task automatic send_word(input ptach_pkg::kind_t kind,
                           input logic [ptach_pkg::PIN_W-1:0] pin);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = pin;
    do @(posedge clk); while (!s_axis_tready);
    if (kind == ptach_pkg::KIND_EDGE) begin
      count_edge(pin);
      n_edges++;
    end else begin
      pending_speeds.push_back(close_window());
    end
  endtask

  // hold off until every speed word is back and any trailing edge has landed
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_reg(input ptach_pkg::reg_idx_t idx,
                          input logic [ptach_pkg::REG_W-1:0] want);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, want})
      note_fail($sformatf("Register %s read exp %0d got %0d", idx.name(), want, prdata));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(input ptach_pkg::reg_idx_t idx,
                           input logic [ptach_pkg::REG_W-1:0] val);
    settle();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {16'h0000, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      ptach_pkg::REG_TACH_PIN_MASK: cfg_pin_mask = val;
      ptach_pkg::REG_SLEW_STEP:     cfg_slew_step = val;
      ptach_pkg::REG_MIN_RPM:       cfg_min_rpm = val;
      default:                      cfg_max_rpm = val;
    endcase
    n_writes++;
    read_reg(idx, val);
  endtask

  task automatic test_reset_defaults();
    read_reg(ptach_pkg::REG_TACH_PIN_MASK, ptach_pkg::RST_TACH_PIN_MASK);
    read_reg(ptach_pkg::REG_SLEW_STEP, ptach_pkg::RST_SLEW_STEP);
    read_reg(ptach_pkg::REG_MIN_RPM, ptach_pkg::RST_MIN_RPM);
    read_reg(ptach_pkg::REG_MAX_RPM, ptach_pkg::RST_MAX_RPM);
    send_word(ptach_pkg::KIND_TICK, 16'h0000);
    repeat (3) send_word(ptach_pkg::KIND_EDGE, 16'h0080);
    send_word(ptach_pkg::KIND_EDGE, 16'h0040);
    send_word(ptach_pkg::KIND_EDGE, 16'h0000);
    send_word(ptach_pkg::KIND_EDGE, 16'hFFFF);
    send_word(ptach_pkg::KIND_EDGE, 16'h0100);
    send_word(ptach_pkg::KIND_TICK, 16'hFFFF);
    repeat (10) send_word(ptach_pkg::KIND_EDGE, 16'h0080);
    send_word(ptach_pkg::KIND_TICK, 16'h0080);
  endtask

  task automatic test_pin_extremes();
    write_reg(ptach_pkg::REG_TACH_PIN_MASK, 16'h0000);
    send_word(ptach_pkg::KIND_EDGE, 16'h0000);
    send_word(ptach_pkg::KIND_EDGE, 16'hFFFF);
    send_word(ptach_pkg::KIND_EDGE, 16'h0000);
    send_word(ptach_pkg::KIND_TICK, 16'h0000);
    write_reg(ptach_pkg::REG_TACH_PIN_MASK, 16'hFFFF);
    send_word(ptach_pkg::KIND_EDGE, 16'hFFFF);
    send_word(ptach_pkg::KIND_EDGE, 16'h0000);
    send_word(ptach_pkg::KIND_EDGE, 16'hFFFF);
    send_word(ptach_pkg::KIND_TICK, 16'hFFFF);
  endtask

  task automatic test_floor_and_ceiling();
    write_reg(ptach_pkg::REG_SLEW_STEP, 16'd1000);
    write_reg(ptach_pkg::REG_MIN_RPM, 16'd200);
    write_reg(ptach_pkg::REG_MAX_RPM, 16'd50);
    repeat (20) send_word(ptach_pkg::KIND_EDGE, 16'hFFFF);
    send_word(ptach_pkg::KIND_TICK, 16'h0000);
    write_reg(ptach_pkg::REG_MIN_RPM, 16'hFFFF);
    send_word(ptach_pkg::KIND_TICK, 16'h0000);
    write_reg(ptach_pkg::REG_MIN_RPM, 16'd0);
    write_reg(ptach_pkg::REG_MAX_RPM, 16'd0);
    send_word(ptach_pkg::KIND_TICK, 16'h0000);
  endtask

  task automatic test_zero_step();
    write_reg(ptach_pkg::REG_SLEW_STEP, 16'd0);
    write_reg(ptach_pkg::REG_MAX_RPM, 16'd3000);
    repeat (30) send_word(ptach_pkg::KIND_EDGE, 16'hFFFF);
    send_word(ptach_pkg::KIND_TICK, 16'h0000);
    send_word(ptach_pkg::KIND_TICK, 16'h0000);
  endtask

  task automatic test_dense_window();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(ptach_pkg::REG_TACH_PIN_MASK, 16'h0001);
    write_reg(ptach_pkg::REG_SLEW_STEP, 16'hFFFF);
    write_reg(ptach_pkg::REG_MIN_RPM, 16'd0);
    write_reg(ptach_pkg::REG_MAX_RPM, 16'hFFFF);
    repeat (150) send_word(ptach_pkg::KIND_EDGE, 16'h0001);
    send_word(ptach_pkg::KIND_TICK, 16'h0000);
    send_word(ptach_pkg::KIND_TICK, 16'h0000);
  endtask

  task automatic shuffle_config();
    logic [ptach_pkg::REG_W-1:0] v;
    case ($urandom_range(3))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      2:       v = 16'h0001 << $urandom_range(15);
      default: v = 16'($urandom_range(65535));
    endcase
    write_reg(ptach_pkg::REG_TACH_PIN_MASK, v);
    case ($urandom_range(4))
      0:       v = 16'd0;
      1:       v = 16'd1;
      2:       v = 16'hFFFF;
      default: v = 16'($urandom_range(400, 1));
    endcase
    write_reg(ptach_pkg::REG_SLEW_STEP, v);
    case ($urandom_range(3))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(3000));
    endcase
    write_reg(ptach_pkg::REG_MIN_RPM, v);
    case ($urandom_range(3))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(4000));
    endcase
    write_reg(ptach_pkg::REG_MAX_RPM, v);
  endtask

  // steady edge rates so the average settles, with stray pins mixed in
  task automatic run_windows(input int budget, input int min_ticks);
    int counted, ticks, rate, n;
    counted = 0;
    ticks = 0;
    rate = 0;
    while (counted < budget || ticks < min_ticks) begin
      if (ticks % 6 == 0) rate = $urandom_range(70);
      n = rate + int'($urandom_range(6)) - 3;
      if (n < 0) n = 0;
      if ($urandom_range(19) == 0) n = $urandom_range(150);
      repeat (n) begin
        if ($urandom_range(7) == 0) send_word(ptach_pkg::KIND_EDGE, 16'($urandom));
        send_word(ptach_pkg::KIND_EDGE, cfg_pin_mask);
      end
      repeat ($urandom_range(2)) send_word(ptach_pkg::KIND_EDGE, 16'($urandom));
      send_word(ptach_pkg::KIND_TICK, 16'($urandom));
      counted += n + 1;
      ticks++;
    end
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (2) begin
      shuffle_config();
      run_windows(200, 6);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    tx_idle_pct = 17;
    rx_idle_pct = 61;
    test_reset_defaults();
    test_pin_extremes();
    test_floor_and_ceiling();
    test_zero_step();
    test_dense_window();
    test_random(17, 61);
    test_random(61, 17);
    test_random(0, 0);
    settle();
    $display("Compared %0d speed words after %0d edge words and %0d register writes,",
             n_checked, n_edges, n_writes);
    $display("covering pin mask extremes, a dense window, zero step and clamping");
    if (mismatches == 0 && pending_speeds.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
